>>> design/kfc_pkg.sv
// ----------------------------------------------------------------------------
// kfc_pkg
// types, codes and sizes shared by the keyed frequency counter table
// ----------------------------------------------------------------------------
package kfc_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int COUNT_BITS    = 16;
   localparam int KEY_BITS      = 16;
   localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
   localparam int OCC_BITS      = $clog2(TABLE_ENTRIES + 1);

   // operation codes
   localparam logic [2:0] OP_INC       = 3'd0;
   localparam logic [2:0] OP_DEC       = 3'd1;
   localparam logic [2:0] OP_RESET     = 3'd2;
   localparam logic [2:0] OP_READ_ID   = 3'd3;
   localparam logic [2:0] OP_READ_SLOT = 3'd4;

   // status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_ABSENT = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;

   typedef struct packed {
      logic [2:0]          operation;
      logic [KEY_BITS-1:0] face_id;
      logic [IDX_BITS-1:0] slot_index;
   } kfc_req_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] count_value;
      logic [KEY_BITS-1:0]   entry_face_id;
      logic [OCC_BITS-1:0]   entries_used;
      logic [1:0]            status;
   } kfc_rsp_type;

   // request travelling down the row of cells
   typedef struct packed {
      logic                  active;
      logic [2:0]            op;
      logic [KEY_BITS-1:0]   key;
      logic [IDX_BITS-1:0]   slot;
      logic [OCC_BITS-1:0]   occ;
      logic                  hit;
      logic                  insert;
      logic [COUNT_BITS-1:0] count;
      logic [KEY_BITS-1:0]   entry;
   } kfc_token_type;

endpackage

>>> design/kfc_cell.sv
// ----------------------------------------------------------------------------
// kfc_cell
// one table entry: holds a key and its counter, serves the passing request
// ----------------------------------------------------------------------------
module kfc_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [kfc_pkg::IDX_BITS-1:0]  cell_idx,
   input  kfc_pkg::kfc_token_type        token_in,
   output kfc_pkg::kfc_token_type        token_out
);

   logic [kfc_pkg::KEY_BITS-1:0]   key_ff,   key_in;
   logic [kfc_pkg::COUNT_BITS-1:0] count_ff, count_in;
   kfc_pkg::kfc_token_type         token_ff, token_in_next;

   logic                            in_use;
   logic                            is_free;
   logic                            key_hit;
   logic                            slot_hit;
   logic [kfc_pkg::COUNT_BITS-1:0]  count_upd;

   assign in_use   = {1'b0, cell_idx} < token_in.occ;
   assign is_free  = {1'b0, cell_idx} == token_in.occ;
   assign key_hit  = token_in.active && !token_in.hit && in_use &&
                     (token_in.op <= kfc_pkg::OP_READ_ID) && (key_ff == token_in.key);
   assign slot_hit = token_in.active && !token_in.hit && in_use &&
                     (token_in.op == kfc_pkg::OP_READ_SLOT) && (cell_idx == token_in.slot);

   // counter after the keyed operation
   always_comb begin
      unique case (token_in.op)
         kfc_pkg::OP_INC: begin
            count_upd = (count_ff == '1) ? count_ff : count_ff + 1'b1;
         end
         kfc_pkg::OP_DEC: begin
            count_upd = (count_ff == '0) ? count_ff : count_ff - 1'b1;
         end
         kfc_pkg::OP_RESET: begin
            count_upd = '0;
         end
         default: begin
            count_upd = count_ff;
         end
      endcase
   end

   always_comb begin
      key_in        = key_ff;
      count_in      = count_ff;
      token_in_next = token_in;
      priority if (key_hit) begin
         count_in            = count_upd;
         token_in_next.hit   = 1'b1;
         token_in_next.count = count_upd;
      end else if (slot_hit) begin
         token_in_next.hit   = 1'b1;
         token_in_next.count = count_ff;
         token_in_next.entry = key_ff;
      end else if (token_in.active && !token_in.hit && is_free &&
                   (token_in.op == kfc_pkg::OP_INC)) begin
         // first unused slot: append the new id
         key_in               = token_in.key;
         count_in             = kfc_pkg::COUNT_BITS'(1);
         token_in_next.hit    = 1'b1;
         token_in_next.insert = 1'b1;
         token_in_next.count  = kfc_pkg::COUNT_BITS'(1);
      end else begin
         token_in_next = token_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      count_ff <= count_in;
      if (reset) begin
         token_ff <= '0;
      end else begin
         token_ff <= token_in_next;
      end
   end

   assign token_out = token_ff;

endmodule

>>> design/keyed_frequency_counter_table.sv
// ----------------------------------------------------------------------------
// keyed_frequency_counter_table
// table of interface ids with request counters, kept in a row of cells
// ----------------------------------------------------------------------------
// each request enters a row of sixteen cells, one cell per table entry,
// and moves one cell per clock; the cell holding the id (or the slot, or
// the first free entry for a new id) updates itself as the request passes.
// one request is in flight at a time: a transfer on req passes the sixteen
// cell registers and then the result register, and a new request is taken
// only after the last one has reached the result register. a request is
// taken only while the result register is empty or being emptied in the
// same cycle.
// ----------------------------------------------------------------------------
module keyed_frequency_counter_table (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  kfc_pkg::kfc_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output kfc_pkg::kfc_rsp_type  rsp_data
);

   localparam int N = kfc_pkg::TABLE_ENTRIES;

   // control state
   logic                          busy_ff,  busy_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [kfc_pkg::OCC_BITS-1:0]  occ_ff,   occ_in;
   kfc_pkg::kfc_rsp_type          rsp_ff,   rsp_in;

   kfc_pkg::kfc_token_type        tok_chain [0:N];
   kfc_pkg::kfc_token_type        tok_done;
   logic [N-1:0]                  act_vec;
   logic                          req_take;
   logic                          rsp_take;

   assign rsp_take  = rsp_valid_ff && rsp_ready;
   assign req_ready = !busy_ff && (!rsp_valid_ff || rsp_ready);
   assign req_take  = req_valid && req_ready;

   // request enters the row at cell 0
   always_comb begin
      tok_chain[0]        = '0;
      tok_chain[0].active = req_take;
      tok_chain[0].op     = req_data.operation;
      tok_chain[0].key    = req_data.face_id;
      tok_chain[0].slot   = req_data.slot_index;
      tok_chain[0].occ    = occ_ff;
   end

   // row of cells, one per table entry
   for (genvar i = 0; i < N; i++) begin : g_cell
      kfc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (kfc_pkg::IDX_BITS'(i)),
         .token_in  (tok_chain[i]),
         .token_out (tok_chain[i+1])
      );
      assign act_vec[i] = tok_chain[i+1].active;
   end

   assign tok_done = tok_chain[N];

   // result formed from the request leaving the last cell
   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      occ_in       = occ_ff;
      rsp_in       = rsp_ff;
      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
      if (req_take) begin
         busy_in = 1'b1;
      end
      if (tok_done.active) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         occ_in       = occ_ff + kfc_pkg::OCC_BITS'(tok_done.insert);
         rsp_in.count_value   = tok_done.hit ? tok_done.count : '0;
         rsp_in.entry_face_id = tok_done.entry;
         rsp_in.entries_used  = occ_ff + kfc_pkg::OCC_BITS'(tok_done.insert);
         priority if (tok_done.hit) begin
            rsp_in.status = kfc_pkg::ST_OK;
         end else if (tok_done.op == kfc_pkg::OP_INC) begin
            // no match and no free slot: insert dropped
            rsp_in.status = kfc_pkg::ST_FULL;
         end else begin
            rsp_in.status = kfc_pkg::ST_ABSENT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         occ_ff       <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         occ_ff       <= occ_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // at most one request in the row
   a_single_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(act_vec))
      else $error("more than one request in flight");

   // occupancy never exceeds the table size
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= kfc_pkg::OCC_BITS'(N))
      else $error("occupancy out of range");

   // a taken request keeps the block busy
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> busy_ff && act_vec[0])
      else $error("request not entered into the row");

   // a dropped insert only happens with a full table
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status == kfc_pkg::ST_FULL) |->
         rsp_ff.entries_used == kfc_pkg::OCC_BITS'(N))
      else $error("full status with free entries");

endmodule
